### rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types, codes and helpers for the dense matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

	// Default sizing
	localparam int unsigned DEF_MAX_DIM   = 16;
	localparam int unsigned DEF_ELEM_BITS = 32;
	localparam int unsigned DEF_FRAC_BITS = 16;

	// Fixed port widths
	localparam int unsigned CFG_W = 5;   // dimension registers, also loop counters
	localparam int unsigned IDX_W = 4;   // row / column index ports
	localparam int unsigned VAL_W = 32;  // element / result value ports
	localparam int unsigned CMD_W = 2;
	localparam int unsigned REG_W = 2;   // config register index

	// Commands
	localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	// Config register indexes
	localparam logic [REG_W-1:0] REG_A_ROWS = 2'd0;
	localparam logic [REG_W-1:0] REG_A_COLS = 2'd1;
	localparam logic [REG_W-1:0] REG_B_ROWS = 2'd2;
	localparam logic [REG_W-1:0] REG_B_COLS = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} mm_state_t;

	// Tag that travels with each multiply-accumulate beat
	typedef struct packed {
		logic             first;     // first term of a dot product
		logic             last_k;    // last term of a dot product
		logic [CFG_W-1:0] col;       // column of C
		logic             last_col;  // last column of the row
	} mm_tag_t;

	// Finished dot product, saturated
	typedef struct packed {
		logic             valid;
		logic [CFG_W-1:0] col;
		logic             last_col;
		logic             sat;
		logic [VAL_W-1:0] value;
	} mm_res_t;

	// Clamp a dimension register to 1 .. max_dim
	function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
			input int unsigned max_dim);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (int'(v) > int'(max_dim)) begin
			r = CFG_W'(max_dim);
		end
		return r;
	endfunction

endpackage

### rtl/mm_store.sv
// ----------------------------------------------------------------------------
// mm_store
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mm_store #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/mm_mac.sv
// ----------------------------------------------------------------------------
// mm_mac
// Multiply-accumulate datapath: registered product, wide exact accumulator,
// then arithmetic shift by the fraction width and saturation.
// ----------------------------------------------------------------------------
module mm_mac import mm_pkg::*; #(
	parameter int unsigned ELEM_BITS = DEF_ELEM_BITS,
	parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  mm_tag_t              in_tag,
	input  logic [ELEM_BITS-1:0] a_elem,
	input  logic [ELEM_BITS-1:0] b_elem,
	output mm_res_t              res,
	output logic                 idle
);

	localparam int unsigned PROD_W = 2 * ELEM_BITS;
	localparam int unsigned ACC_W  = PROD_W + CFG_W;  // exact for up to 31 terms

	logic                     valid_s2;
	mm_tag_t                  tag_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic                     valid_s3;
	mm_tag_t                  tag_s3;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [ACC_W-1:0]  shifted;
	logic [ACC_W-ELEM_BITS:0] upper;
	logic                     fits;
	logic [ELEM_BITS-1:0]     value_e;

	// stage 2: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2  <= in_tag;
		prod_s2 <= $signed(a_elem) * $signed(b_elem);
	end

	// stage 3: accumulate, restart on the first term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			acc_q    <= '0;
		end else begin
			valid_s3 <= valid_s2;
			if (valid_s2) begin
				acc_q <= (tag_s2.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_s3 <= tag_s2;
	end

	// shift out the fraction and clip to the element range
	always_comb begin
		shifted = acc_q >>> FRAC_BITS;
		upper   = shifted[ACC_W-1:ELEM_BITS-1];
		fits    = (&upper) | ~(|upper);
		if (fits) begin
			value_e = shifted[ELEM_BITS-1:0];
		end else if (acc_q[ACC_W-1]) begin
			value_e = {1'b1, {(ELEM_BITS-1){1'b0}}};
		end else begin
			value_e = {1'b0, {(ELEM_BITS-1){1'b1}}};
		end
	end

	assign res.valid    = valid_s3 && tag_s3.last_k;
	assign res.col      = tag_s3.col;
	assign res.last_col = tag_s3.last_col;
	assign res.sat      = !fits;
	assign res.value    = VAL_W'($signed(value_e));

	assign idle = !valid_s2 && !valid_s3;

endmodule

### rtl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// Dense matrix product C = A x B in signed fixed point, one row of C per
// compute command, operands held in two on-chip element stores.
// ----------------------------------------------------------------------------
// Loads leave busy low.
// A compute issues one multiply-accumulate per cycle from the two store read
// ports and returns one result per column of C; busy holds from start until
// the multiply-accumulate pipeline has drained.
// An order mismatch result appears the cycle after start; results cannot be stalled.
// Reset sets dimension registers to 16, clears control; store contents undefined.
module matrix_multiply import mm_pkg::*; #(
	parameter int unsigned MAX_DIM   = DEF_MAX_DIM,
	parameter int unsigned ELEM_BITS = DEF_ELEM_BITS,
	parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	// config write port
	input  logic             cfg_we,
	input  logic [REG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// command channel
	input  logic             start,
	output logic             busy,
	input  logic [CMD_W-1:0] cmd,
	input  logic [IDX_W-1:0] row_index,
	input  logic [IDX_W-1:0] col_index,
	input  logic [VAL_W-1:0] element_value,
	// result channel
	output logic             result_valid,
	output logic [IDX_W-1:0] out_row,
	output logic [IDX_W-1:0] out_col,
	output logic [VAL_W-1:0] out_value,
	output logic             order_error,
	output logic             saturated,
	output logic             last
);

	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	// dimension registers
	logic [CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [CFG_W-1:0] ar, ac, br, bc;

	mm_state_t        state_q, state_d;
	logic [CFG_W-1:0] k_q, j_q;
	logic [IDX_W-1:0] row_q;

	logic             accept;
	logic             load_ok;
	logic             we_a, we_b;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic [ELEM_BITS-1:0] rdata_a, rdata_b;

	logic             issue;
	logic             last_k, last_col;
	logic             go_run, go_err;
	mm_tag_t          tag_d;
	logic             valid_s1;
	mm_tag_t          tag_s1;

	mm_res_t          res;
	logic             mac_idle;

	logic             result_valid_q;
	logic [IDX_W-1:0] out_row_q, out_col_q;
	logic [VAL_W-1:0] out_value_q;
	logic             order_error_q, saturated_q, last_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= CFG_W'(16);
			a_cols_q <= CFG_W'(16);
			b_rows_q <= CFG_W'(16);
			b_cols_q <= CFG_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A_ROWS: a_rows_q <= cfg_data;
				REG_A_COLS: a_cols_q <= cfg_data;
				REG_B_ROWS: b_rows_q <= cfg_data;
				REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ar = eff_dim(a_rows_q, MAX_DIM);
	assign ac = eff_dim(a_cols_q, MAX_DIM);
	assign br = eff_dim(b_rows_q, MAX_DIM);
	assign bc = eff_dim(b_cols_q, MAX_DIM);

	// command decode
	assign accept  = start && !busy;
	assign load_ok = (int'(row_index) < int'(MAX_DIM)) && (int'(col_index) < int'(MAX_DIM));
	assign we_a    = accept && (cmd == CMD_LOAD_A) && load_ok;
	assign we_b    = accept && (cmd == CMD_LOAD_B) && load_ok;
	assign waddr   = ADDR_W'(int'(row_index) * int'(MAX_DIM) + int'(col_index));
	assign go_err  = accept && (cmd == CMD_COMPUTE) && (ac != br);
	assign go_run  = accept && (cmd == CMD_COMPUTE) && (ac == br)
		&& ({1'b0, row_index} < ar);

	// stores
	mm_store #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (element_value[ELEM_BITS-1:0]),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	mm_store #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (element_value[ELEM_BITS-1:0]),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// read addresses: A[row][k], B[k][j]
	assign raddr_a = ADDR_W'(int'(row_q) * int'(MAX_DIM) + int'(k_q));
	assign raddr_b = ADDR_W'(int'(k_q) * int'(MAX_DIM) + int'(j_q));

	assign last_k   = (k_q == ac - CFG_W'(1));
	assign last_col = (j_q == bc - CFG_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (go_run) state_d = ST_RUN;
			ST_RUN:   if (last_k && last_col) state_d = ST_DRAIN;
			ST_DRAIN: if (!valid_s1 && mac_idle) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		issue = 1'b0;
		busy  = 1'b1;
		case (state_q)
			ST_IDLE:  busy  = 1'b0;
			ST_RUN:   issue = 1'b1;
			ST_DRAIN: issue = 1'b0;
			default:  busy  = 1'b1;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			j_q      <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (go_run) begin
				row_q <= row_index;
				k_q   <= '0;
				j_q   <= '0;
			end else if (issue) begin
				if (last_k) begin
					k_q <= '0;
					j_q <= j_q + CFG_W'(1);
				end else begin
					k_q <= k_q + CFG_W'(1);
				end
			end
		end
	end

	// tag is registered alongside the store read data
	always_comb begin
		tag_d.first    = (k_q == '0);
		tag_d.last_k   = last_k;
		tag_d.col      = j_q;
		tag_d.last_col = last_col;
	end

	always_ff @(posedge clk) begin
		tag_s1 <= tag_d;
	end

	mm_mac #(.ELEM_BITS(ELEM_BITS), .FRAC_BITS(FRAC_BITS)) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_tag   (tag_s1),
		.a_elem   (rdata_a),
		.b_elem   (rdata_b),
		.res      (res),
		.idle     (mac_idle)
	);

	// result register: product beat or order error beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= res.valid || go_err;
		end
	end

	always_ff @(posedge clk) begin
		if (go_err) begin
			out_row_q     <= row_index;
			out_col_q     <= '0;
			out_value_q   <= '0;
			order_error_q <= 1'b1;
			saturated_q   <= 1'b0;
			last_q        <= 1'b1;
		end else begin
			out_row_q     <= row_q;
			out_col_q     <= res.col[IDX_W-1:0];
			out_value_q   <= res.value;
			order_error_q <= 1'b0;
			saturated_q   <= res.sat;
			last_q        <= res.last_col;
		end
	end

	assign result_valid = result_valid_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign out_value    = out_value_q;
	assign order_error  = order_error_q;
	assign saturated    = saturated_q;
	assign last         = last_q;

	// checks
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	a_err_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && order_error |-> $past(start && !busy) && last)
		else $error("order error beat without a compute command");

	a_prod_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !order_error |-> $past(busy) && busy)
		else $error("product beat outside a compute");

	a_no_issue_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		go_run |-> !valid_s1 && mac_idle)
		else $error("compute started while pipeline active");

endmodule

### bench/mm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mm_checker
// Scoreboard for matrix_multiply. Snoops the config, command and result
// ports, mirrors both element stores and the dimension registers, works out
// every row of C that an accepted compute beat should produce, and compares
// each result beat in order against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module mm_checker import mm_pkg::*; #(
	parameter int unsigned MAX_DIM   = DEF_MAX_DIM,
	parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [REG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             start,
	input  logic             busy,
	input  logic [CMD_W-1:0] cmd,
	input  logic [IDX_W-1:0] row_index,
	input  logic [IDX_W-1:0] col_index,
	input  logic [VAL_W-1:0] element_value,
	input  logic             result_valid,
	input  logic [IDX_W-1:0] out_row,
	input  logic [IDX_W-1:0] out_col,
	input  logic [VAL_W-1:0] out_value,
	input  logic             order_error,
	input  logic             saturated,
	input  logic             last,
	output int unsigned      fail_count,
	output int unsigned      pending
);

	// One element of C as it leaves the block
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic             order_err;
		logic             sat;
		logic             last;
	} c_elem_t;

	// Exact dot product needs 2*VAL_W bits plus log2(MAX_DIM) of growth
	localparam int SUM_W = 2 * VAL_W + 8;
	localparam logic signed [SUM_W-1:0] Q_HI = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] Q_LO = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

	logic [VAL_W-1:0] a_mem [MAX_DIM*MAX_DIM];
	logic [VAL_W-1:0] b_mem [MAX_DIM*MAX_DIM];
	logic [CFG_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
	c_elem_t          c_expected_q [$];

	// Dimension as the block uses it: 0 reads as 1, oversize reads as MAX_DIM
	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > MAX_DIM) begin
			return MAX_DIM;
		end
		return 32'(v);
	endfunction

	// C[row][col] over depth terms: exact sum, floor shift, clip to element range
	function automatic c_elem_t c_element(input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input int unsigned depth);
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] q;
		c_elem_t e;
		sum = '0;
		for (int k = 0; k < depth; k++) begin
			sum = sum + $signed(a_mem[row * MAX_DIM + k]) *
				$signed(b_mem[k * MAX_DIM + col]);
		end
		q = sum >>> FRAC_BITS;
		e.row = row;
		e.col = col;
		e.order_err = 1'b0;
		e.last = 1'b0;
		e.sat = (q > Q_HI) || (q < Q_LO);
		if (q > Q_HI) begin
			e.value = Q_HI[VAL_W-1:0];
		end else if (q < Q_LO) begin
			e.value = Q_LO[VAL_W-1:0];
		end else begin
			e.value = q[VAL_W-1:0];
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		c_elem_t got;
		c_elem_t want;
		int unsigned ar, ac, br, bc;
		if (!arst_n) begin
			a_rows_reg = CFG_W'(MAX_DIM);
			a_cols_reg = CFG_W'(MAX_DIM);
			b_rows_reg = CFG_W'(MAX_DIM);
			b_cols_reg = CFG_W'(MAX_DIM);
			c_expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// result beat: compare against the oldest outstanding element
			if (result_valid) begin
				got = {out_row, out_col, out_value, order_error, saturated, last};
				if (c_expected_q.size() == 0) begin
					if (fail_count < 10) begin
						$display("%0t: unexpected C beat row %0d col %0d value %h err %b sat %b last %b",
							$realtime, got.row, got.col, got.value, got.order_err, got.sat,
							got.last);
					end
					fail_count++;
				end else begin
					want = c_expected_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10) begin
							$display("%0t: C beat mismatch: expected row %0d col %0d value %h err %b sat %b last %b",
								$realtime, want.row, want.col, want.value, want.order_err,
								want.sat, want.last);
							$display("%0t:                 actual   row %0d col %0d value %h err %b sat %b last %b",
								$realtime, got.row, got.col, got.value, got.order_err,
								got.sat, got.last);
						end
						fail_count++;
					end
				end
			end

			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_A_ROWS: a_rows_reg = cfg_data;
					REG_A_COLS: a_cols_reg = cfg_data;
					REG_B_ROWS: b_rows_reg = cfg_data;
					REG_B_COLS: b_cols_reg = cfg_data;
					default: ;
				endcase
			end

			// accepted command beat
			if (start && !busy) begin
				ar = clamp_dim(a_rows_reg);
				ac = clamp_dim(a_cols_reg);
				br = clamp_dim(b_rows_reg);
				bc = clamp_dim(b_cols_reg);
				case (cmd)
					CMD_LOAD_A: a_mem[row_index * MAX_DIM + col_index] = element_value;
					CMD_LOAD_B: b_mem[row_index * MAX_DIM + col_index] = element_value;
					CMD_COMPUTE: begin
						if (ac != br) begin
							// inner sizes disagree: single error beat, no product
							want = '{row: row_index, col: '0, value: '0, order_err: 1'b1,
								sat: 1'b0, last: 1'b1};
							c_expected_q.push_back(want);
						end else if (row_index < ar) begin
							for (int j = 0; j < bc; j++) begin
								want = c_element(row_index, IDX_W'(j), ac);
								want.last = (j == bc - 1);
								c_expected_q.push_back(want);
							end
						end
					end
					default: ;  // unused opcode is dropped
				endcase
			end
			pending = c_expected_q.size();
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for matrix_multiply. A directed opening hits the
// element extremes, both saturation directions, rows past the used height,
// the unused opcode, out-of-range dimension codes and the inner size
// mismatch; then random phases with new dimensions load operands and ask
// for rows of C, with random gaps between beats. Checking is in mm_checker.
// ----------------------------------------------------------------------------
module testbench;
	import mm_pkg::*;

	localparam int unsigned MAX_DIM = DEF_MAX_DIM;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [VAL_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] ELEM_MIN = 32'h8000_0000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [REG_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             start;
	logic             busy;
	logic [CMD_W-1:0] cmd;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] col_index;
	logic [VAL_W-1:0] element_value;
	logic             result_valid;
	logic [IDX_W-1:0] out_row;
	logic [IDX_W-1:0] out_col;
	logic [VAL_W-1:0] out_value;
	logic             order_error;
	logic             saturated;
	logic             last;
	int unsigned      fail_count;
	int unsigned      pending;

	// which store entries hold data, so a compute never reads an unwritten one
	bit          a_loaded [MAX_DIM*MAX_DIM];
	bit          b_loaded [MAX_DIM*MAX_DIM];
	int unsigned use_a_rows, use_a_cols, use_b_rows, use_b_cols;
	int unsigned items_sent;
	bit          no_idle;

	matrix_multiply dut (.*);

	mm_checker c_check (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// mostly small magnitudes so sums stay in range, some wide and some extreme
	function automatic logic [VAL_W-1:0] rand_elem();
		logic [VAL_W-1:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return {{14{r[17]}}, r[17:0]};
			6, 7: return {{6{r[25]}}, r[25:0]};
			8: return r;
			default: begin
				case ($urandom_range(0, 3))
					0: return ELEM_MAX;
					1: return ELEM_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	function automatic int unsigned pick_dim();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: return $urandom_range(1, 4);
			7, 8: return $urandom_range(5, MAX_DIM - 1);
			default: return MAX_DIM;
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned n;
		n = $urandom_range(0, 99);
		if (n < 50) begin
			return 0;
		end
		if (n < 85) begin
			return $urandom_range(1, 3);
		end
		if (n < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	// register code for a dimension; with odd set, 1 and MAX_DIM get codes outside 1..MAX_DIM
	function automatic logic [CFG_W-1:0] dim_code(input int unsigned v, input bit odd);
		if (odd && v == 1) begin
			return '0;
		end
		if (odd && v == MAX_DIM) begin
			return CFG_W'($urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1));
		end
		return CFG_W'(v);
	endfunction

	task automatic idle_gap();
		int unsigned n;
		n = no_idle ? 0 : pick_gap();
		if (n != 0) begin
			start <= 1'b0;
			cmd <= CMD_W'($urandom);
			row_index <= IDX_W'($urandom);
			col_index <= IDX_W'($urandom);
			element_value <= $urandom;
			repeat (n) @(negedge clk);
		end
	endtask

	// one command beat and any idle gap; entered and left on a falling edge, start left high if no gap
	task automatic send_beat(input logic [CMD_W-1:0] c, input int unsigned r,
			input int unsigned k, input logic [VAL_W-1:0] v);
		logic [IDX_W-1:0] r_i;
		logic [IDX_W-1:0] k_i;
		r_i = IDX_W'(r);
		k_i = IDX_W'(k);
		start <= 1'b1;
		cmd <= c;
		row_index <= r_i;
		col_index <= k_i;
		element_value <= v;
		while (busy) @(negedge clk);
		@(negedge clk);
		if (c == CMD_LOAD_A) begin
			a_loaded[int'(r_i) * MAX_DIM + int'(k_i)] = 1'b1;
		end else if (c == CMD_LOAD_B) begin
			b_loaded[int'(r_i) * MAX_DIM + int'(k_i)] = 1'b1;
		end
		if (c != CMD_UNUSED) begin
			items_sent++;
		end
		idle_gap();
	endtask

	// load whatever operands this row still lacks, then ask for the row
	task automatic compute_row(input int unsigned r);
		if (use_a_cols == use_b_rows && r < use_a_rows) begin
			for (int k = 0; k < use_a_cols; k++) begin
				if (!a_loaded[r * MAX_DIM + k]) begin
					send_beat(CMD_LOAD_A, r, k, rand_elem());
				end
				for (int j = 0; j < use_b_cols; j++) begin
					if (!b_loaded[k * MAX_DIM + j]) begin
						send_beat(CMD_LOAD_B, k, j, rand_elem());
					end
				end
			end
		end
		send_beat(CMD_COMPUTE, r, $urandom, $urandom);
	endtask

	// wait until every result is in and the block has gone quiet
	task automatic settle();
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic set_dims(input int unsigned ar, input int unsigned ac,
			input int unsigned br, input int unsigned bc, input bit odd);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_A_ROWS;
		cfg_data <= dim_code(ar, odd);
		@(negedge clk);
		cfg_index <= REG_A_COLS;
		cfg_data <= dim_code(ac, odd);
		@(negedge clk);
		cfg_index <= REG_B_ROWS;
		cfg_data <= dim_code(br, odd);
		@(negedge clk);
		cfg_index <= REG_B_COLS;
		cfg_data <= dim_code(bc, odd);
		@(negedge clk);
		cfg_we <= 1'b0;
		use_a_rows = ar;
		use_a_cols = ac;
		use_b_rows = br;
		use_b_cols = bc;
	endtask

	initial begin
		int unsigned ar, ac, br, bc, r, op;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_A_ROWS;
		cfg_data = '0;
		start = 1'b0;
		cmd = CMD_LOAD_A;
		row_index = '0;
		col_index = '0;
		element_value = '0;
		no_idle = 1'b0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 2x2 by 2x2: row 0 clips high and low, row 1 stays in range
		set_dims(2, 2, 2, 2, 1'b0);
		send_beat(CMD_LOAD_A, 0, 0, ELEM_MAX);
		send_beat(CMD_LOAD_A, 0, 1, ELEM_MIN);
		send_beat(CMD_LOAD_A, 1, 0, 32'h0001_0000);  // 1.0
		send_beat(CMD_LOAD_A, 1, 1, 32'h0000_8000);  // 0.5
		send_beat(CMD_LOAD_B, 0, 0, ELEM_MAX);
		send_beat(CMD_LOAD_B, 0, 1, ELEM_MIN);
		send_beat(CMD_LOAD_B, 1, 0, ELEM_MIN);
		send_beat(CMD_LOAD_B, 1, 1, 32'h0002_0000);  // 2.0
		compute_row(0);
		compute_row(1);
		compute_row(2);  // past the used height: silent
		send_beat(CMD_UNUSED, 1, 1, ELEM_MAX);
		send_beat(CMD_LOAD_A, MAX_DIM - 1, MAX_DIM - 1, '1);  // outside dims, inside store
		send_beat(CMD_LOAD_B, MAX_DIM - 1, MAX_DIM - 1, '0);
		compute_row(MAX_DIM - 1);

		// out-of-range codes: zero reads as one, oversize reads as MAX_DIM
		set_dims(MAX_DIM, 1, 1, 2, 1'b1);
		compute_row(1);
		// oversize a_cols against one-row B: order error on any row
		set_dims(2, MAX_DIM, 1, 2, 1'b1);
		compute_row(9);
		compute_row(0);

		// random phases, each with its own dimensions
		while (items_sent < 380) begin
			ar = pick_dim();
			ac = pick_dim();
			bc = pick_dim();
			br = ($urandom_range(0, 7) == 0) ? pick_dim() : ac;
			set_dims(ar, ac, br, bc, $urandom_range(0, 3) == 0);
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(3, 10)) begin
				op = $urandom_range(0, 19);
				if (op < 10) begin
					compute_row($urandom_range(0, ar - 1));
				end else if (op < 12) begin
					compute_row($urandom_range(0, MAX_DIM - 1));
				end else if (op < 15) begin
					// overwrite an operand inside the region in use
					if ($urandom_range(0, 1)) begin
						send_beat(CMD_LOAD_A, $urandom_range(0, ar - 1),
							$urandom_range(0, ac - 1), rand_elem());
					end else begin
						send_beat(CMD_LOAD_B, $urandom_range(0, br - 1),
							$urandom_range(0, bc - 1), rand_elem());
					end
				end else if (op == 15) begin
					send_beat($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A, $urandom,
						$urandom, rand_elem());
				end else if (op == 16) begin
					send_beat(CMD_UNUSED, $urandom, $urandom, $urandom);
				end else if (op < 19) begin
					// fresh row of A, then that row of C
					r = $urandom_range(0, ar - 1);
					for (int k = 0; k < ac; k++) begin
						send_beat(CMD_LOAD_A, r, k, rand_elem());
					end
					compute_row(r);
				end else begin
					// fresh column of B, then some row of C
					r = $urandom_range(0, bc - 1);
					for (int k = 0; k < br; k++) begin
						send_beat(CMD_LOAD_B, k, r, rand_elem());
					end
					compute_row($urandom_range(0, ar - 1));
				end
			end
		end

		settle();
		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### matrix_multiply.f
rtl/mm_pkg.sv
rtl/mm_store.sv
rtl/mm_mac.sv
rtl/matrix_multiply.sv
bench/mm_checker.sv
bench/testbench.sv
